// File: rtl/saq_pkg.sv
// Shared types and constants of the sorted alarm queue.
// Holds the operation and status codes, the field widths and the default depth.
// Depends on nothing.
package saq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam int KEY_W    = 32;
  localparam int OP_W     = 2;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;

  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd2;
  localparam logic [OP_W-1:0] OP_DISMISS = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef logic [KEY_W-1:0] key_t;

endpackage

// File: rtl/saq_store.sv
// Alarm key memory of the sorted alarm queue: one write port, one read port
// with registered read data.
// Depends on saq_pkg.
module saq_store #(
  parameter int DEPTH  = saq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  saq_pkg::key_t     wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output saq_pkg::key_t     rd_data
);
  import saq_pkg::*;

  key_t mem [DEPTH];
  key_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/saq_cmp.sv
// Shared key comparator of the sorted alarm queue.
// Packed keys order lexicographically as plain unsigned numbers. Depends on saq_pkg.
module saq_cmp (
  input  saq_pkg::key_t stored_key,
  input  saq_pkg::key_t probe_key,
  output logic          stored_gt
);
  import saq_pkg::*;

  always_comb begin
    stored_gt = stored_key > probe_key;
  end

endmodule

// File: rtl/sorted_alarm_queue_top.sv
// Top level of the sorted alarm queue: sequencer, count and result register.
// Depends on saq_pkg, saq_store and saq_cmp.
//
// The queue keeps up to QUEUE_DEPTH alarm timestamps sorted earliest first in
// a single-port-read memory, and every operation returns one result with the
// head entry, the count and a status. One operation is in work at a time:
// in_tready is high only while the block is idle, and it drops from the
// accepting edge until the result transaction completes. An insert walks from
// the tail toward the head, with a memory read, then a compare and write
// through the shared comparator, for each entry moved; a delete or dismiss
// shifts the entries behind the removed one, a read then a write per entry. A
// tick or a rejected operation goes straight to the head read. Every operation
// reads the head (S_HEAD_RD), forms the result (S_HEAD_CMP) and presents it
// in S_OUT until out_tready takes it. The alarm memory needs no clearing
// after reset; entries beyond the count are never read.
module sorted_alarm_queue_top #(
  parameter int QUEUE_DEPTH = saq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // Fields from bit 0 up: year, month, day, hour, minute, position, zero fill.
  input  logic [saq_pkg::IN_DATA_W-1:0]  in_tdata,
  // Fields from bit 0 up: op.
  input  logic [saq_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // Fields from bit 0 up: ringing, has_next, next_year, next_month, next_day,
  // next_hour, next_minute, entry_count, status, zero fill.
  output logic [saq_pkg::OUT_DATA_W-1:0] out_tdata
);
  import saq_pkg::*;

  localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int PW     = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int EXT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_RD   = 3'd1;
  localparam logic [2:0] S_INS_CMP  = 3'd2;
  localparam logic [2:0] S_DEL_RD   = 3'd3;
  localparam logic [2:0] S_DEL_WR   = 3'd4;
  localparam logic [2:0] S_HEAD_RD  = 3'd5;
  localparam logic [2:0] S_HEAD_CMP = 3'd6;
  localparam logic [2:0] S_OUT      = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]   k_r, k_nxt;
  key_t                key_r, key_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                mem_wr_en;
  logic [ADDR_W-1:0]   mem_wr_addr;
  key_t                mem_wr_data;
  logic                mem_rd_en;
  logic [ADDR_W-1:0]   mem_rd_addr;
  key_t                mem_rd_data;
  logic                stored_gt;

  key_t                in_key;
  logic [OP_W-1:0]     in_op;
  logic [PW-1:0]       in_pos;
  logic [PW-1:0]       pos_idx;
  logic                pos_bad;
  logic [CNT_W-1:0]    k_plus1;
  key_t                head;
  logic                ringing;
  logic [EXT_W-1:0]    cnt_ext;

  assign in_key  = {in_tdata[11:0], in_tdata[15:12], in_tdata[20:16],
                    in_tdata[25:21], in_tdata[31:26]};
  assign in_op   = in_tuser[1:0];
  assign in_pos  = PW'(in_tdata[36:32]);
  assign pos_idx = in_pos - PW'(1);
  assign pos_bad = (in_pos == '0) || (in_pos > PW'(cnt_r));
  assign k_plus1 = CNT_W'(k_r) + CNT_W'(1);

  saq_store #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // The one comparator serves the insert walk and the tick due test.
  saq_cmp u_cmp (
    .stored_key (mem_rd_data),
    .probe_key  (key_r),
    .stored_gt  (stored_gt)
  );

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    k_nxt        = k_r;
    key_nxt      = key_r;
    op_nxt       = op_r;
    status_nxt   = status_r;
    out_data_nxt = out_data_r;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = k_r;
    mem_wr_data  = key_r;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = k_r;
    head         = '0;
    ringing      = 1'b0;
    cnt_ext      = EXT_W'(cnt_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          key_nxt    = in_key;
          op_nxt     = in_op;
          status_nxt = ST_OK;
          state_nxt  = S_HEAD_RD;
          unique case (in_op)
            OP_INSERT: begin
              if (cnt_r == CNT_W'(QUEUE_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                k_nxt     = cnt_r[ADDR_W-1:0];
                state_nxt = S_INS_RD;
              end
            end
            OP_DELETE: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (pos_bad) begin
                status_nxt = ST_RANGE;
              end else begin
                k_nxt     = pos_idx[ADDR_W-1:0];
                state_nxt = S_DEL_RD;
              end
            end
            OP_TICK: begin
              state_nxt = S_HEAD_RD;
            end
            OP_DISMISS: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                k_nxt     = '0;
                state_nxt = S_DEL_RD;
              end
            end
            default: begin
              state_nxt = S_HEAD_RD;
            end
          endcase
        end
      end

      S_INS_RD: begin
        if (k_r == '0) begin
          mem_wr_en = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_HEAD_RD;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = k_r - ADDR_W'(1);
          state_nxt   = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        mem_wr_en = 1'b1;
        if (stored_gt) begin
          // Later entry moves one place toward the tail.
          mem_wr_data = mem_rd_data;
          k_nxt       = k_r - ADDR_W'(1);
          state_nxt   = S_INS_RD;
        end else begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_HEAD_RD;
        end
      end

      S_DEL_RD: begin
        if (k_plus1 >= cnt_r) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_HEAD_RD;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = k_plus1[ADDR_W-1:0];
          state_nxt   = S_DEL_WR;
        end
      end

      S_DEL_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = mem_rd_data;
        k_nxt       = k_r + ADDR_W'(1);
        state_nxt   = S_DEL_RD;
      end

      S_HEAD_RD: begin
        mem_rd_en   = cnt_r != '0;
        mem_rd_addr = '0;
        state_nxt   = S_HEAD_CMP;
      end

      S_HEAD_CMP: begin
        if (cnt_r != '0) begin
          head    = mem_rd_data;
          ringing = (op_r == OP_TICK) && !stored_gt;
        end
        out_data_nxt = {7'b0, status_r, cnt_ext[COUNT_W-1:0], head[5:0], head[10:6],
                        head[15:11], head[19:16], head[31:20], cnt_r != '0, ringing};
        state_nxt    = S_OUT;
      end

      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    key_r      <= key_nxt;
    op_r       <= op_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = state_r == S_OUT;
  assign out_tdata  = out_data_r;

  // The count never exceeds the queue depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("alarm count above queue depth");

  // A full rejection is reported only while the queue is full.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_data_r[40:39] == ST_FULL |-> cnt_r == CNT_W'(QUEUE_DEPTH))
    else $error("full status with free entries");

  // An empty queue reports an all-zero head and no ringing.
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_data_r[1] |-> out_data_r[33:0] == '0 && cnt_r == '0)
    else $error("empty queue reports a head entry");

  // A new operation is taken only after the previous result has left.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> in_tready && !out_tvalid)
    else $error("result handshake did not return to idle");

endmodule
